// ----- hdl/matrix3x3_inverse_assert.svh -----
// Assertion macros for the 3x3 matrix inverse project.
// Used by the port checker; needs signals named clock and reset in scope.
`ifndef MATRIX3X3_INVERSE_ASSERT_SVH
`define MATRIX3X3_INVERSE_ASSERT_SVH

// Checked only outside reset.
`define M3I_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define M3I_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hdl/m3i_pkg.sv -----
// Shared constants and types of the 3x3 matrix inverse.
// No dependencies.
package m3i_pkg;

   localparam int ELEM_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int NUM_ELEMS      = 9;

   // Determinant status carried from the front end to the output stage.
   typedef struct packed {
      logic singular;
      logic det_ovf;
   } det_flags_type;

endpackage

// ----- hdl/matrix3x3_inverse.sv -----
// 3x3 matrix inverse by the adjugate method, signed fixed point (Q16.16 by default).
// Takes one matrix per clock while req_tready is high and returns one result per
// matrix, in order, through five stages of products, adjugate and determinant, then
// nine divider lanes of ELEM_WIDTH+2 stages (a range check, then one quotient bit per
// stage), then the output register. The whole pipeline advances whenever the output
// register is empty or being taken, so req_tready drops only while a finished result
// is held back. A zero determinant returns zeros with singular set; results that do
// not fit saturate and set overflow.
module matrix3x3_inverse #(
   parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // a00, a01, a02, a10, a11, a12, a20, a21, a22 from the lowest bit up
   input  logic [((9*ELEM_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // inv00 .. inv22 row by row, then det_value, from the lowest bit up
   output logic [((10*ELEM_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // singular, overflow from the lowest bit up
   output logic [1:0] rsp_tuser
);
   localparam int W   = ELEM_WIDTH;
   localparam int N   = m3i_pkg::NUM_ELEMS;
   localparam int L   = W + 2;
   localparam int LAT = 5 + L;
   localparam int OTW = ((10*ELEM_WIDTH+7)/8)*8;

   logic                  en;
   logic                  rsp_valid_ff;
   logic [LAT-1:0]        vld_ff;
   logic signed [W-1:0]   elem [N];
   logic [2*W:0]          adj_mag [N];
   logic                  adj_neg [N];
   logic [3*W+2:0]        det_mag;
   logic                  det_neg;
   logic [W-1:0]          det_value;
   m3i_pkg::det_flags_type det_flags;
   logic [W-1:0]          dval_ff [L];
   m3i_pkg::det_flags_type dflg_ff [L];
   logic [W:0]            quo [N];
   logic                  big [N];
   logic                  qneg [N];
   logic [W-1:0]          inv [N];
   logic [W-1:0]          det_out;
   logic                  singular;
   logic                  overflow;
   logic [10*W-1:0]       packed_out;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      for (int k = 0; k < N; k++) begin
         elem[k] = req_tdata[k*W +: W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[LAT-2:0], req_tvalid};
         rsp_valid_ff <= vld_ff[LAT-1];
      end
   end

   m3i_front #(.W(W), .F(FRAC_BITS)) u_front (
      .clock     (clock),
      .en        (en),
      .elem      (elem),
      .adj_mag   (adj_mag),
      .adj_neg   (adj_neg),
      .det_mag   (det_mag),
      .det_neg   (det_neg),
      .det_value (det_value),
      .det_flags (det_flags)
   );

   for (genvar k = 0; k < N; k++) begin : g_lane
      m3i_lane #(.W(W), .F(FRAC_BITS)) u_lane (
         .clock   (clock),
         .en      (en),
         .mag     (adj_mag[k]),
         .den     (det_mag),
         .neg     (adj_neg[k] ^ det_neg),
         .quo     (quo[k]),
         .big     (big[k]),
         .neg_out (qneg[k])
      );
   end

   // The determinant result waits beside the lanes.
   always_ff @(posedge clock) begin
      if (en) begin
         dval_ff[0] <= det_value;
         dflg_ff[0] <= det_flags;
         for (int i = 1; i < L; i++) begin
            dval_ff[i] <= dval_ff[i-1];
            dflg_ff[i] <= dflg_ff[i-1];
         end
      end
   end

   m3i_merge #(.W(W)) u_merge (
      .clock     (clock),
      .en        (en),
      .quo       (quo),
      .big       (big),
      .neg       (qneg),
      .det_value (dval_ff[L-1]),
      .det_flags (dflg_ff[L-1]),
      .inv       (inv),
      .det_out   (det_out),
      .singular  (singular),
      .overflow  (overflow)
   );

   always_comb begin
      for (int k = 0; k < N; k++) begin
         packed_out[k*W +: W] = inv[k];
      end
      packed_out[N*W +: W] = det_out;
   end

   assign rsp_tdata = OTW'(packed_out);
   assign rsp_tuser = {overflow, singular};
endmodule

// ----- hdl/m3i_front.sv -----
// Front end: products, adjugate, determinant, magnitudes and signs.
// Five register stages. Uses m3i_pkg.
module m3i_front #(
   parameter int W = m3i_pkg::ELEM_WIDTH_DEF,
   parameter int F = m3i_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [W-1:0]  elem [m3i_pkg::NUM_ELEMS],
   output logic [2*W:0]         adj_mag [m3i_pkg::NUM_ELEMS],
   output logic                 adj_neg [m3i_pkg::NUM_ELEMS],
   output logic [3*W+2:0]       det_mag,
   output logic                 det_neg,
   output logic [W-1:0]         det_value,
   output m3i_pkg::det_flags_type det_flags
);
   localparam int PW = 2 * W;
   localparam int AW = 2 * W + 1;
   localparam int TW = 2 * W + 1;
   localparam int DW = 3 * W + 3;
   localparam logic [DW-1:0] LIM = DW'(1) << (W - 1);
   localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

   logic signed [PW-1:0] prod_ff [18];
   logic signed [PW-1:0] prod_in [18];
   logic signed [W-1:0]  row1_ff [3];
   logic signed [W-1:0]  row2_ff [3];
   logic signed [AW-1:0] adj2_ff [9];
   logic signed [AW-1:0] adj3_ff [9];
   logic signed [AW-1:0] adj4_ff [9];
   logic signed [TW-1:0] plo_ff [3];
   logic signed [TW-1:0] phi_ff [3];
   logic signed [TW-1:0] plo_in [3];
   logic signed [TW-1:0] phi_in [3];
   logic signed [DW-1:0] det_ff;
   logic signed [DW-1:0] det_in;
   logic [DW-1:0]        dmag_in;
   logic [DW-1:0]        dq;
   logic [DW-1:0]        dq_neg;
   logic [W-1:0]         dval_in;
   logic                 dovf_in;

   always_comb begin
      prod_in[0]  = elem[4] * elem[8];  prod_in[1]  = elem[5] * elem[7];
      prod_in[2]  = elem[2] * elem[7];  prod_in[3]  = elem[1] * elem[8];
      prod_in[4]  = elem[1] * elem[5];  prod_in[5]  = elem[2] * elem[4];
      prod_in[6]  = elem[5] * elem[6];  prod_in[7]  = elem[3] * elem[8];
      prod_in[8]  = elem[0] * elem[8];  prod_in[9]  = elem[2] * elem[6];
      prod_in[10] = elem[2] * elem[3];  prod_in[11] = elem[0] * elem[5];
      prod_in[12] = elem[3] * elem[7];  prod_in[13] = elem[4] * elem[6];
      prod_in[14] = elem[1] * elem[6];  prod_in[15] = elem[0] * elem[7];
      prod_in[16] = elem[0] * elem[4];  prod_in[17] = elem[1] * elem[3];
   end

   // The determinant term a * adj is split at bit W of adj to keep multipliers narrow.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         plo_in[k] = row2_ff[k] * $signed({1'b0, adj2_ff[3*k][W-1:0]});
         phi_in[k] = row2_ff[k] * $signed(adj2_ff[3*k][AW-1:W]);
      end
   end

   always_comb begin
      det_in = '0;
      for (int k = 0; k < 3; k++) begin
         det_in = det_in + (DW'(phi_ff[k]) <<< W) + DW'(plo_ff[k]);
      end
   end

   always_comb begin
      dmag_in = det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
      dq      = dmag_in >> (2 * F);
      dq_neg  = -dq;
      dovf_in = 1'b0;
      if (det_ff == 0) begin
         dval_in = '0;
      end else if (!det_ff[DW-1]) begin
         dovf_in = (dq >= LIM);
         dval_in = dovf_in ? MAXV : dq[W-1:0];
      end else begin
         dovf_in = (dq > LIM);
         dval_in = dovf_in ? MINV : dq_neg[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         for (int k = 0; k < 3; k++) begin
            row1_ff[k] <= elem[k];
         end
         row2_ff <= row1_ff;
         for (int k = 0; k < 9; k++) begin
            adj2_ff[k] <= AW'(prod_ff[2*k]) - AW'(prod_ff[2*k+1]);
         end
         adj3_ff <= adj2_ff;
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         adj4_ff <= adj3_ff;
         det_ff  <= det_in;
         for (int k = 0; k < 9; k++) begin
            adj_neg[k] <= adj4_ff[k][AW-1];
            adj_mag[k] <= adj4_ff[k][AW-1] ? AW'(-adj4_ff[k]) : AW'(adj4_ff[k]);
         end
         det_mag            <= dmag_in;
         det_neg            <= det_ff[DW-1];
         det_value          <= dval_in;
         det_flags.singular <= (det_ff == 0);
         det_flags.det_ovf  <= dovf_in;
      end
   end
endmodule

// ----- hdl/m3i_lane.sv -----
// One divider lane: quotient of (|adj| << 2F) by |det|, one quotient bit per stage.
// Uses m3i_pkg for defaults.
module m3i_lane #(
   parameter int W = m3i_pkg::ELEM_WIDTH_DEF,
   parameter int F = m3i_pkg::FRAC_BITS_DEF
) (
   input  logic           clock,
   input  logic           en,
   input  logic [2*W:0]   mag,
   input  logic [3*W+2:0] den,
   input  logic           neg,
   output logic [W:0]     quo,
   output logic           big,
   output logic           neg_out
);
   localparam int Q  = W + 1;
   localparam int DW = 3 * W + 3;
   localparam int CW = DW + Q;

   logic [CW-1:0] rem_ff [Q];
   logic [DW-1:0] den_ff [Q];
   logic [Q-1:0]  q_ff   [Q+1];
   logic          big_ff [Q+1];
   logic          neg_ff [Q+1];
   logic [CW-1:0] num;

   assign num = CW'(mag) << (2 * F);

   // Quotients of 2^Q and above are flagged here and saturate later.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num;
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         big_ff[0] <= (num >= (CW'(den) << Q));
         neg_ff[0] <= neg;
      end
   end

   for (genvar i = 1; i <= Q; i++) begin : g_step
      localparam int B = Q - i;
      logic [CW-1:0] trial;
      logic          ge;
      assign trial = CW'(den_ff[i-1]) << B;
      assign ge    = (rem_ff[i-1] >= trial);
      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[i]   <= q_ff[i-1] | (Q'(ge) << B);
            big_ff[i] <= big_ff[i-1];
            neg_ff[i] <= neg_ff[i-1];
         end
      end
      if (i < Q) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i] <= ge ? (rem_ff[i-1] - trial) : rem_ff[i-1];
               den_ff[i] <= den_ff[i-1];
            end
         end
      end
   end

   assign quo     = q_ff[Q];
   assign big     = big_ff[Q];
   assign neg_out = neg_ff[Q];
endmodule

// ----- hdl/m3i_merge.sv -----
// Merge stage: saturates the nine lane quotients and combines the status flags.
// Output register of the block. Uses m3i_pkg.
module m3i_merge #(
   parameter int W = m3i_pkg::ELEM_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [W:0]             quo [m3i_pkg::NUM_ELEMS],
   input  logic                   big [m3i_pkg::NUM_ELEMS],
   input  logic                   neg [m3i_pkg::NUM_ELEMS],
   input  logic [W-1:0]           det_value,
   input  m3i_pkg::det_flags_type det_flags,
   output logic [W-1:0]           inv [m3i_pkg::NUM_ELEMS],
   output logic [W-1:0]           det_out,
   output logic                   singular,
   output logic                   overflow
);
   localparam logic [W:0]   LIM  = (W+1)'(1) << (W - 1);
   localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

   logic [W-1:0] inv_in [m3i_pkg::NUM_ELEMS];
   logic [W:0]   qn;
   logic         sat;
   logic         ovf_in;

   always_comb begin
      ovf_in = det_flags.det_ovf;
      qn     = '0;
      sat    = 1'b0;
      for (int k = 0; k < m3i_pkg::NUM_ELEMS; k++) begin
         qn = -quo[k];
         if (neg[k]) begin
            sat       = big[k] || (quo[k] > LIM);
            inv_in[k] = sat ? MINV : qn[W-1:0];
         end else begin
            sat       = big[k] || (quo[k] >= LIM);
            inv_in[k] = sat ? MAXV : quo[k][W-1:0];
         end
         ovf_in = ovf_in | sat;
      end
      if (det_flags.singular) begin
         for (int k = 0; k < m3i_pkg::NUM_ELEMS; k++) begin
            inv_in[k] = '0;
         end
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         inv      <= inv_in;
         det_out  <= det_flags.singular ? '0 : det_value;
         singular <= det_flags.singular;
         overflow <= ovf_in;
      end
   end
endmodule

// ----- hdl/m3i_checker.sv -----
// Port checker for the 3x3 matrix inverse, bound to the top level.
// Uses matrix3x3_inverse_assert.svh and m3i_pkg.
`include "matrix3x3_inverse_assert.svh"

module m3i_checker #(
   parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((10*ELEM_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input logic [1:0] rsp_tuser
);
   `M3I_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "result valid after reset")
   `M3I_ASSERT(a_ready_rule, req_tready == (!rsp_tvalid || rsp_tready), "input stalled without cause")
   `M3I_ASSERT(a_sing_no_ovf, rsp_tvalid && rsp_tuser[0] |-> !rsp_tuser[1], "singular with overflow")
   `M3I_ASSERT(a_sing_zero, rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0, "singular result not zero")
   `M3I_ASSERT(a_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled transfer changed")
endmodule

bind matrix3x3_inverse m3i_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_m3i_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
